[design/dllm_pkg.sv]
package dllm_pkg;

   // Default size of the node pool.
   localparam int NODES_DEFAULT = 64;

   // Fixed widths of the transfer fields.
   localparam int NODE_W = 6;
   localparam int OP_W   = 3;

   // Operation codes carried by req_opcode. Codes six and seven are refused.
   typedef enum logic [OP_W-1:0] {
      OP_ADD_HEAD = 3'd0,
      OP_ADD_TAIL = 3'd1,
      OP_REM_HEAD = 3'd2,
      OP_REM_TAIL = 3'd3,
      OP_REM_NODE = 3'd4,
      OP_QUERY    = 3'd5
   } opcode_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;     // clear one membership entry
      logic accept;    // capture the request and read the target's entries
      logic exec;      // apply the operation and capture the result
      logic link;      // write the old end node's link
      logic res_move;  // move the captured result into the output register
   } dllm_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;  // clearing pass is at its last entry
      logic need_link;   // the add in progress needs a second link write
   } dllm_sts_type;

endpackage

[design/dllm_ctrl.sv]
module dllm_ctrl
   import dllm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  dllm_sts_type sts,
   output dllm_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_EXEC  = 4'b0100,
      ST_LINK  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      res_pending_ff, res_pending_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      res_move;
   logic      can_take;
   logic      accept;

   always_comb begin
      // The staged result moves out whenever the output register is free or being emptied.
      res_move = res_pending_ff && (!rsp_valid_ff || !rsp_stall);
      can_take = (state_ff == ST_IDLE) && (!res_pending_ff || res_move);
      accept   = req_valid && can_take;

      cmd.clear    = (state_ff == ST_CLEAR);
      cmd.accept   = accept;
      cmd.exec     = (state_ff == ST_EXEC);
      cmd.link     = (state_ff == ST_LINK);
      cmd.res_move = res_move;

      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = sts.need_link ? ST_LINK : ST_IDLE;
         end
         ST_LINK: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      res_pending_in = cmd.exec || (res_pending_ff && !res_move);
      rsp_valid_in   = res_move || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         res_pending_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         res_pending_ff <= res_pending_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign req_stall = !can_take;
   assign rsp_valid = rsp_valid_ff;

endmodule

[design/dllm_dpath.sv]
module dllm_dpath
   import dllm_pkg::*;
#(
   parameter int NODES = NODES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  dllm_cmd_type      cmd,
   output dllm_sts_type      sts,
   input  logic [OP_W-1:0]   req_opcode,
   input  logic [NODE_W-1:0] req_node,
   output logic [NODE_W-1:0] rsp_removed_node,
   output logic              rsp_ok,
   output logic              rsp_empty_res,
   output logic [NODE_W-1:0] rsp_head_node,
   output logic [NODE_W-1:0] rsp_tail_node
);

   localparam int IDX_W  = $clog2(NODES);
   localparam int LINK_W = $clog2(NODES + 1);
   localparam logic [LINK_W-1:0] NIL = LINK_W'(NODES);

   // Link tables and membership bits.
   logic [LINK_W-1:0] next_mem [NODES];
   logic [LINK_W-1:0] prev_mem [NODES];
   logic              in_mem   [NODES];

   logic [LINK_W-1:0] head_ff, head_in;
   logic [LINK_W-1:0] tail_ff, tail_in;
   logic [IDX_W-1:0]  clr_ff;
   opcode_type        op_ff;
   logic [IDX_W-1:0]  tgt_ff;
   logic              tgt_ok_ff;
   logic              in_rd_ff;
   logic [LINK_W-1:0] next_rd_ff;
   logic [LINK_W-1:0] prev_rd_ff;
   logic [IDX_W-1:0]  fix_ff, fix_in;

   logic [NODE_W-1:0] res_removed_ff, res_head_ff, res_tail_ff;
   logic              res_ok_ff, res_empty_ff;
   logic [NODE_W-1:0] out_removed_ff, out_head_ff, out_tail_ff;
   logic              out_ok_ff, out_empty_ff;

   opcode_type        op_sel;
   logic              node_ok;
   logic [IDX_W-1:0]  tgt;
   logic              tgt_ok;
   logic              is_add, is_rem, ok, need_link, empty;
   logic [LINK_W-1:0] tgt_link;
   logic              next_we, prev_we, in_we;
   logic [IDX_W-1:0]  next_wa, prev_wa, in_wa;
   logic [LINK_W-1:0] next_wd, prev_wd;
   logic              in_wd;
   logic [NODE_W-1:0] res_removed, res_head, res_tail;

   // Request decode: pick the node whose entries are read.
   always_comb begin
      op_sel  = opcode_type'(req_opcode);
      node_ok = (int'(req_node) < NODES);
      unique case (op_sel)
         OP_REM_HEAD: begin
            tgt    = IDX_W'(head_ff);
            tgt_ok = (head_ff != NIL);
         end
         OP_REM_TAIL: begin
            tgt    = IDX_W'(tail_ff);
            tgt_ok = (tail_ff != NIL);
         end
         default: begin
            tgt    = IDX_W'(req_node);
            tgt_ok = node_ok;
         end
      endcase
   end

   // Operation: pointer updates and link table writes.
   always_comb begin
      is_add = (op_ff == OP_ADD_HEAD) || (op_ff == OP_ADD_TAIL);
      is_rem = (op_ff == OP_REM_HEAD) || (op_ff == OP_REM_TAIL) || (op_ff == OP_REM_NODE);
      ok     = (op_ff == OP_QUERY) ||
               (tgt_ok_ff && ((is_add && !in_rd_ff) || (is_rem && in_rd_ff)));
      tgt_link = LINK_W'(tgt_ff);

      head_in   = head_ff;
      tail_in   = tail_ff;
      fix_in    = fix_ff;
      need_link = 1'b0;
      next_we   = 1'b0;
      next_wa   = tgt_ff;
      next_wd   = NIL;
      prev_we   = 1'b0;
      prev_wa   = tgt_ff;
      prev_wd   = NIL;
      in_we     = 1'b0;
      in_wa     = tgt_ff;
      in_wd     = 1'b0;

      if (cmd.clear) begin
         in_we = 1'b1;
         in_wa = clr_ff;
      end

      if (cmd.exec && ok && is_add) begin
         in_we   = 1'b1;
         in_wd   = 1'b1;
         next_we = 1'b1;
         prev_we = 1'b1;
         if (op_ff == OP_ADD_HEAD) begin
            next_wd = head_ff;
            prev_wd = NIL;
            head_in = tgt_link;
            fix_in  = IDX_W'(head_ff);
            if (head_ff == NIL) tail_in = tgt_link;
            else need_link = 1'b1;
         end else begin
            prev_wd = tail_ff;
            next_wd = NIL;
            tail_in = tgt_link;
            fix_in  = IDX_W'(tail_ff);
            if (tail_ff == NIL) head_in = tgt_link;
            else need_link = 1'b1;
         end
      end

      if (cmd.exec && ok && is_rem) begin
         in_we = 1'b1;
         if (prev_rd_ff != NIL) begin
            next_we = 1'b1;
            next_wa = IDX_W'(prev_rd_ff);
            next_wd = next_rd_ff;
         end else begin
            head_in = next_rd_ff;
         end
         if (next_rd_ff != NIL) begin
            prev_we = 1'b1;
            prev_wa = IDX_W'(next_rd_ff);
            prev_wd = prev_rd_ff;
         end else begin
            tail_in = prev_rd_ff;
         end
      end

      if (cmd.link) begin
         if (op_ff == OP_ADD_HEAD) begin
            prev_we = 1'b1;
            prev_wa = fix_ff;
            prev_wd = tgt_link;
         end else begin
            next_we = 1'b1;
            next_wa = fix_ff;
            next_wd = tgt_link;
         end
      end

      empty       = (head_in == NIL);
      res_head    = empty ? '0 : NODE_W'(head_in);
      res_tail    = (empty || tail_in == NIL) ? '0 : NODE_W'(tail_in);
      res_removed = (ok && is_rem) ? NODE_W'(tgt_ff) : '0;

      sts.clear_last = (clr_ff == IDX_W'(NODES - 1));
      sts.need_link  = need_link;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= NIL;
         tail_ff <= NIL;
         clr_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         if (cmd.clear) clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff      <= op_sel;
         tgt_ff     <= tgt;
         tgt_ok_ff  <= tgt_ok;
         in_rd_ff   <= in_mem[tgt];
         next_rd_ff <= next_mem[tgt];
         prev_rd_ff <= prev_mem[tgt];
      end
      if (cmd.exec) begin
         fix_ff         <= fix_in;
         res_removed_ff <= res_removed;
         res_ok_ff      <= ok;
         res_empty_ff   <= empty;
         res_head_ff    <= res_head;
         res_tail_ff    <= res_tail;
      end
      if (cmd.res_move) begin
         out_removed_ff <= res_removed_ff;
         out_ok_ff      <= res_ok_ff;
         out_empty_ff   <= res_empty_ff;
         out_head_ff    <= res_head_ff;
         out_tail_ff    <= res_tail_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (next_we) next_mem[next_wa] <= next_wd;
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
      if (in_we)   in_mem[in_wa]     <= in_wd;
   end

   assign rsp_removed_node = out_removed_ff;
   assign rsp_ok           = out_ok_ff;
   assign rsp_empty_res    = out_empty_ff;
   assign rsp_head_node    = out_head_ff;
   assign rsp_tail_node    = out_tail_ff;

endmodule

[design/doubly_linked_list_manager.sv]
// Doubly linked list manager over a pool of NODES node indices. Each request transfer
// carries an opcode (add at head, add at tail, remove head, remove tail, remove a named
// node, query) and a node index, and produces exactly one response transfer with the
// removed node, an ok flag, the empty flag and the head and tail nodes after the
// operation. Adding a node that is already linked, removing from an empty list or
// removing a node that is not linked is refused with ok low and no change of state.
// After reset the block clears its membership memory one entry per cycle, NODES
// entries in all, and holds req_stall high during that pass. One operation is in
// flight at a time. Every operation first reads the target node's membership bit and
// links from single-port memories into registers as it is accepted, and then applies
// its update in an execute step. A successful add to a list that already holds nodes
// writes the old end node's link in a separate link step, because each link memory
// has one write port. The response is staged and then held in an output register, so
// a stalled response does not stop the next request.
module doubly_linked_list_manager
   import dllm_pkg::*;
#(
   parameter int NODES = NODES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [OP_W-1:0]   req_opcode,
   input  logic [NODE_W-1:0] req_node,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [NODE_W-1:0] rsp_removed_node,
   output logic              rsp_ok,
   output logic              rsp_empty_res,
   output logic [NODE_W-1:0] rsp_head_node,
   output logic [NODE_W-1:0] rsp_tail_node
);

   dllm_cmd_type cmd;
   dllm_sts_type sts;

   // The controller sequences clear, accept, execute and link steps and owns both
   // valid flags of the result path.
   dllm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the link memories, the head and tail pointers and the
   // result registers.
   dllm_dpath #(
      .NODES (NODES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_opcode       (req_opcode),
      .req_node         (req_node),
      .rsp_removed_node (rsp_removed_node),
      .rsp_ok           (rsp_ok),
      .rsp_empty_res    (rsp_empty_res),
      .rsp_head_node    (rsp_head_node),
      .rsp_tail_node    (rsp_tail_node)
   );

   // Once a request is taken, the block is busy in the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while the previous one is still executing");

   // An empty list reports zero for both end nodes.
   a_empty_ends_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_res) |-> (rsp_head_node == '0 && rsp_tail_node == '0))
      else $error("empty list reported with a nonzero end node");

   // Clearing, executing and link writing never overlap.
   a_steps_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear, cmd.accept, cmd.exec, cmd.link}))
      else $error("controller issued overlapping steps");

   // A link step only follows an execute step that asked for it.
   a_link_only_when_needed: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && !sts.need_link) |=> !cmd.link)
      else $error("link write issued without a pending add");

endmodule

[dv/testbench.sv]
module testbench;
   import dllm_pkg::*;

   // The node pool is fixed at the package default. A link value equal to the pool size
   // marks the end of the chain, just as in the block.
   localparam int POOL        = NODES_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RAND_ITEMS  = 1400;
   localparam logic [6:0] NIL_LINK = 7'(POOL);

   // The two opcode values that the block must refuse.
   localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

   // One response transfer, field by field.
   typedef struct packed {
      logic [NODE_W-1:0] removed_node;
      logic              ok;
      logic              empty_res;
      logic [NODE_W-1:0] head_node;
      logic [NODE_W-1:0] tail_node;
   } list_result_type;

   // The tracker keeps its own copy of the linked list: both link tables, the
   // membership bits and the two end pointers. Every accepted request is applied to
   // this copy, and the response that the block must give is queued. Responses are
   // then checked in order against that queue.
   class list_tracker;
      logic [6:0]      next_tab [POOL];
      logic [6:0]      prev_tab [POOL];
      bit              member   [POOL];
      logic [6:0]      head_ptr;
      logic [6:0]      tail_ptr;
      int              length;
      int              peak;
      int              refused;
      int              removals;
      int              errors;
      list_result_type pending[$];

      function new();
         foreach (member[i]) begin
            member[i]   = 1'b0;
            next_tab[i] = '0;
            prev_tab[i] = '0;
         end
         head_ptr = NIL_LINK;
         tail_ptr = NIL_LINK;
      endfunction

      // Takes a member node out of the chain. Its neighbors are joined, and an end
      // pointer moves whenever the node sat at that end.
      function void unlink(logic [6:0] n);
         logic [6:0] p;
         logic [6:0] nx;
         p  = prev_tab[n[5:0]];
         nx = next_tab[n[5:0]];
         if (p < POOL) next_tab[p[5:0]] = nx;
         else head_ptr = nx;
         if (nx < POOL) prev_tab[nx[5:0]] = p;
         else tail_ptr = p;
         member[n[5:0]] = 1'b0;
         length--;
         removals++;
      endfunction

      function void apply_request(logic [OP_W-1:0] op, logic [NODE_W-1:0] node);
         list_result_type r;
         logic [6:0]      n;
         logic [6:0]      t;
         logic            empty;
         r = '0;
         n = {1'b0, node};
         case (op)
            OP_ADD_HEAD: begin
               if (!member[node]) begin
                  next_tab[node] = head_ptr;
                  prev_tab[node] = NIL_LINK;
                  if (head_ptr < POOL) prev_tab[head_ptr[5:0]] = n;
                  else tail_ptr = n;
                  head_ptr     = n;
                  member[node] = 1'b1;
                  length++;
                  r.ok = 1'b1;
               end
            end
            OP_ADD_TAIL: begin
               if (!member[node]) begin
                  prev_tab[node] = tail_ptr;
                  next_tab[node] = NIL_LINK;
                  if (tail_ptr < POOL) next_tab[tail_ptr[5:0]] = n;
                  else head_ptr = n;
                  tail_ptr     = n;
                  member[node] = 1'b1;
                  length++;
                  r.ok = 1'b1;
               end
            end
            OP_REM_HEAD, OP_REM_TAIL: begin
               t = (op == OP_REM_HEAD) ? head_ptr : tail_ptr;
               if (t < POOL && member[t[5:0]]) begin
                  unlink(t);
                  r.removed_node = t[5:0];
                  r.ok           = 1'b1;
               end
            end
            OP_REM_NODE: begin
               if (member[node]) begin
                  unlink(n);
                  r.removed_node = node;
                  r.ok           = 1'b1;
               end
            end
            OP_QUERY: r.ok = 1'b1;
            default: ;
         endcase
         if (!r.ok) refused++;
         if (length > peak) peak = length;
         empty       = !(head_ptr < POOL);
         r.empty_res = empty;
         r.head_node = empty ? '0 : head_ptr[5:0];
         r.tail_node = (empty || !(tail_ptr < POOL)) ? '0 : tail_ptr[5:0];
         pending.push_back(r);
      endfunction

      function void field_check(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_response(list_result_type got);
         list_result_type want;
         if (pending.size() == 0) begin
            $display("%0t: response with no request outstanding, actual %p", $time, got);
            errors++;
         end else begin
            want = pending.pop_front();
            field_check("removed_node", 32'(want.removed_node), 32'(got.removed_node));
            field_check("ok", 32'(want.ok), 32'(got.ok));
            field_check("empty_res", 32'(want.empty_res), 32'(got.empty_res));
            field_check("head_node", 32'(want.head_node), 32'(got.head_node));
            field_check("tail_node", 32'(want.tail_node), 32'(got.tail_node));
         end
      endfunction
   endclass

   // All inputs of the block start at a known value.
   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_valid  = 1'b0;
   logic [OP_W-1:0]   req_opcode = '0;
   logic [NODE_W-1:0] req_node   = '0;
   logic              rsp_stall  = 1'b0;
   logic              req_stall;
   logic              rsp_valid;
   logic [NODE_W-1:0] rsp_removed_node;
   logic              rsp_ok;
   logic              rsp_empty_res;
   logic [NODE_W-1:0] rsp_head_node;
   logic [NODE_W-1:0] rsp_tail_node;

   list_tracker tracker = new();
   int          cycle_count = 0;
   int          items_sent  = 0;
   int          responses   = 0;

   doubly_linked_list_manager DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_node         (req_node),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_removed_node (rsp_removed_node),
      .rsp_ok           (rsp_ok),
      .rsp_empty_res    (rsp_empty_res),
      .rsp_head_node    (rsp_head_node),
      .rsp_tail_node    (rsp_tail_node)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The watchdog ends a run that hangs. The limit is far above the slowest correct
   // run, which includes the clearing pass after reset and heavy response stalls.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time,
                  tracker.pending.size());
         $display("doubly_linked_list_manager: mismatch");
         $finish;
      end
   end

   // The receiver checks every response transfer, using the values from before the
   // edge. Its stall level is redrawn at random during the run, from never stalling to
   // stalling on most cycles, so that back pressure lands on every phase of an operation.
   int stall_percent = 0;
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         tracker.check_response({rsp_removed_node, rsp_ok, rsp_empty_res,
                                 rsp_head_node, rsp_tail_node});
         responses++;
      end
      if (cycle_count % 64 == 0) begin
         case ($urandom_range(4))
            0, 1: stall_percent = 0;
            2: stall_percent = 25;
            3: stall_percent = 50;
            default: stall_percent = 90;
         endcase
      end
      rsp_stall <= !reset && ($urandom_range(99) < stall_percent);
   end

   // Presents one request and holds it until the transfer happens. The valid stays
   // high on return, so the caller decides whether the next request follows at once
   // or a gap comes first.
   task automatic transfer_item(input logic [OP_W-1:0] op, input logic [NODE_W-1:0] node);
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_node   <= node;
      do @(posedge clock); while (req_stall);
      tracker.apply_request(op, node);
      items_sent++;
   endtask

   initial begin
      int               burst_left;
      int               gap;
      int               mode;
      int               pick;
      logic [OP_W-1:0]  op;
      logic [NODE_W-1:0] node;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The empty list is probed first with a query, every remove and the
      // two unused opcodes. Then the ends are filled with the lowest and highest node,
      // duplicates and absent nodes are refused, and nodes come out of the middle, the
      // ends and finally the last one, which empties the list again.
      transfer_item(OP_QUERY, 6'd0);
      transfer_item(OP_REM_HEAD, 6'd0);
      transfer_item(OP_REM_TAIL, 6'd63);
      transfer_item(OP_REM_NODE, 6'd5);
      transfer_item(OP_UNUSED_LO, 6'd0);
      transfer_item(OP_UNUSED_HI, 6'd63);
      transfer_item(OP_ADD_HEAD, 6'd0);
      transfer_item(OP_ADD_TAIL, 6'd63);
      transfer_item(OP_ADD_HEAD, 6'd0);
      transfer_item(OP_ADD_TAIL, 6'd63);
      transfer_item(OP_ADD_HEAD, 6'd63);
      transfer_item(OP_REM_NODE, 6'd5);
      transfer_item(OP_ADD_TAIL, 6'd21);
      transfer_item(OP_ADD_HEAD, 6'd42);
      transfer_item(OP_REM_NODE, 6'd0);
      transfer_item(OP_REM_HEAD, 6'd17);
      transfer_item(OP_REM_TAIL, 6'd9);
      transfer_item(OP_QUERY, 6'd63);
      transfer_item(OP_REM_NODE, 6'd63);
      transfer_item(OP_REM_NODE, 6'd63);
      transfer_item(OP_ADD_TAIL, 6'd7);
      transfer_item(OP_REM_HEAD, 6'd0);
      transfer_item(OP_ADD_HEAD, 6'd33);
      transfer_item(OP_REM_TAIL, 6'd0);

      // Random part. The mix is drawn anew every hundred requests from growing,
      // shrinking and balanced, so the list runs from empty up to the full pool and
      // back. Named removes mostly target a member node, and a few requests carry the
      // unused opcodes. The sender works in bursts with idle gaps between them, and
      // some bursts are long enough to run with no gaps at all.
      burst_left = $urandom_range(1, 20);
      mode       = 0;
      for (int i = 0; i < RAND_ITEMS; i++) begin
         if (i % 100 == 0) mode = $urandom_range(2);
         pick = $urandom_range(99);
         node = NODE_W'($urandom_range(POOL - 1));
         if (pick < 4) begin
            op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
         end else if (pick < 10) begin
            op = OP_QUERY;
         end else if (pick < (mode == 0 ? 75 : mode == 1 ? 35 : 55)) begin
            op = $urandom_range(1) ? OP_ADD_TAIL : OP_ADD_HEAD;
         end else begin
            case ($urandom_range(2))
               0: op = OP_REM_HEAD;
               1: op = OP_REM_TAIL;
               default: begin
                  op = OP_REM_NODE;
                  // Walk forward to the next member, wrapping at the pool size.
                  if ($urandom_range(3) != 0)
                     for (int k = 0; k < POOL && !tracker.member[node]; k++)
                        node = node + 1'b1;
               end
            endcase
         end
         transfer_item(op, node);
         burst_left--;
         if (burst_left == 0) begin
            gap = ($urandom_range(9) == 0) ? $urandom_range(8, 20) : $urandom_range(3);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = ($urandom_range(5) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 20);
         end
      end
      req_valid <= 1'b0;

      // Wait for every outstanding response, then let the clock run on so that any extra
      // response from the block is still caught.
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      $display("Sent %0d requests and checked %0d responses; %0d requests were refused.",
               items_sent, responses, tracker.refused);
      $display("Nodes removed: %0d; the list grew to %0d of %0d nodes at its longest.",
               tracker.removals, tracker.peak, POOL);
      if (tracker.errors == 0 && tracker.pending.size() == 0) begin
         $display("doubly_linked_list_manager: match");
      end else begin
         $display("doubly_linked_list_manager: mismatch");
      end
      $finish;
   end

endmodule
